// File: hw/rtl/law_pkg.sv
// Shared types and constants for the landmark association block.
`timescale 1ns / 1ps
package law_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_POSE = 2'd1;
  localparam logic [1:0] OP_OBS  = 2'd2;

  localparam logic [1:0] REG_COUNT  = 2'd0;
  localparam logic [1:0] REG_XSCALE = 2'd1;
  localparam logic [1:0] REG_YSCALE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_lm;    // write table entry
    logic set_pose;   // latch pose, clear cost
    logic start_obs;  // latch observation
    logic mul_x;      // product step for map x
    logic mul_y;      // product step for map y
    logic fin_map;    // add pose and saturate
    logic scan_rd;    // issue table read
    logic scan_cmp;   // compare returned distance
    logic cost_a;     // squared distances
    logic cost_b;     // scaled products
    logic out_load;   // load output register
  } law_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;
  } law_sts_t;

  // Quarter-wave sine, Q1.14, 33 entries
  function automatic logic [14:0] quarter_sine(input logic [5:0] k);
    logic [14:0] v;
    case (k)
      6'd0: v = 15'd0;      6'd1: v = 15'd804;    6'd2: v = 15'd1606;
      6'd3: v = 15'd2404;   6'd4: v = 15'd3196;   6'd5: v = 15'd3981;
      6'd6: v = 15'd4756;   6'd7: v = 15'd5520;   6'd8: v = 15'd6270;
      6'd9: v = 15'd7005;   6'd10: v = 15'd7723;  6'd11: v = 15'd8423;
      6'd12: v = 15'd9102;  6'd13: v = 15'd9760;  6'd14: v = 15'd10394;
      6'd15: v = 15'd11003; 6'd16: v = 15'd11585; 6'd17: v = 15'd12140;
      6'd18: v = 15'd12665; 6'd19: v = 15'd13160; 6'd20: v = 15'd13623;
      6'd21: v = 15'd14053; 6'd22: v = 15'd14449; 6'd23: v = 15'd14811;
      6'd24: v = 15'd15137; 6'd25: v = 15'd15426; 6'd26: v = 15'd15679;
      6'd27: v = 15'd15893; 6'd28: v = 15'd16069; 6'd29: v = 15'd16207;
      6'd30: v = 15'd16305; 6'd31: v = 15'd16364; 6'd32: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Signed Q1.14 sine of a 128-step angle
  function automatic logic signed [15:0] sine_q14(input logic [6:0] step);
    logic [14:0] mag;
    logic [5:0]  off;
    off = {1'b0, step[4:0]};
    mag = step[5] ? quarter_sine(6'd32 - off) : quarter_sine(off);
    return step[6] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// File: hw/rtl/landmark_association_weighting_top.sv
// Top level: config registers, controller and datapath.
// One observation searches n landmarks (one table read per cycle) between
// request and result. Loads and pose updates complete without leaving idle.
// A new request is taken only once the previous observation has finished.
// Asynchronous active-low reset clears control, pose and cost and sets the
// config registers to defaults; the landmark table and payloads are not reset.
`timescale 1ns / 1ps
module landmark_association_weighting_top #(
  parameter int MAX_LANDMARKS = 64,
  parameter int COORD_BITS    = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode_i,
  input  logic [5:0]                   landmark_slot_i,
  input  logic signed [COORD_BITS-1:0] landmark_x_i,
  input  logic signed [COORD_BITS-1:0] landmark_y_i,
  input  logic signed [COORD_BITS-1:0] pose_x_i,
  input  logic signed [COORD_BITS-1:0] pose_y_i,
  input  logic [15:0]                  heading_i,
  input  logic signed [COORD_BITS-1:0] obs_x_i,
  input  logic signed [COORD_BITS-1:0] obs_y_i,
  input  logic                         final_obs_i,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [5:0]                   match_index_o,
  output logic signed [COORD_BITS-1:0] map_x_o,
  output logic signed [COORD_BITS-1:0] map_y_o,
  output logic [31:0]                  term_cost_o,
  output logic [31:0]                  total_cost_o,
  output logic                         particle_done_o,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [15:0]                  cfg_data
);

  localparam int IDX_BITS = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;

  logic [6:0]  count_q;
  logic [15:0] xs_q, ys_q;
  law_pkg::law_cmd_t cmd;
  law_pkg::law_sts_t sts;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 7'd64;
      xs_q <= 16'd256;
      ys_q <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        law_pkg::REG_COUNT:  count_q <= cfg_data[6:0];
        law_pkg::REG_XSCALE: xs_q <= cfg_data;
        law_pkg::REG_YSCALE: ys_q <= cfg_data;
        default: ;
      endcase
    end
  end

  law_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .opcode_i, .in_ready,
    .out_valid, .out_ready, .sts_i(sts), .cmd_o(cmd)
  );

  law_dp #(
    .MAX_LANDMARKS(MAX_LANDMARKS), .COORD_BITS(COORD_BITS), .IDX_BITS(IDX_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .landmark_count(count_q), .x_error_scale(xs_q), .y_error_scale(ys_q),
    .landmark_slot(landmark_slot_i), .landmark_x(landmark_x_i),
    .landmark_y(landmark_y_i), .pose_x(pose_x_i), .pose_y(pose_y_i),
    .heading(heading_i), .obs_x(obs_x_i), .obs_y(obs_y_i),
    .final_obs(final_obs_i), .out_ready, .out_valid,
    .match_index(match_index_o), .map_x(map_x_o), .map_y(map_y_o),
    .term_cost(term_cost_o), .total_cost(total_cost_o),
    .particle_done(particle_done_o)
  );

  // A result is only raised at the end of an observation sequence
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(cmd.out_load)) else $error("stray result");
  // No new request while a result is pending and not taken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |-> !in_ready) else $error("result overrun");
  // Start, product, map and output commands are never raised together
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start_obs, cmd.mul_x, cmd.fin_map, cmd.out_load}))
    else $error("command overlap");

endmodule

// File: hw/rtl/law_ctrl.sv
// Sequencer for landmark loads, pose updates and observation scans.
`timescale 1ns / 1ps
module law_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  input  logic [1:0]        opcode_i,
  output logic              in_ready,
  input  logic              out_valid,
  input  logic              out_ready,
  input  law_pkg::law_sts_t sts_i,
  output law_pkg::law_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MY   = 4'd2;
  localparam logic [3:0] S_MAP  = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_DRN1 = 4'd5;
  localparam logic [3:0] S_DRN2 = 4'd6;
  localparam logic [3:0] S_CA   = 4'd7;
  localparam logic [3:0] S_CB   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       acc;

  // Output register must be free before a new request starts
  assign in_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (opcode_i)
            law_pkg::OP_LOAD: cmd_o.load_lm = 1'b1;
            law_pkg::OP_POSE: cmd_o.set_pose = 1'b1;
            law_pkg::OP_OBS: begin
              cmd_o.start_obs = 1'b1;
              state_d = S_MX;
            end
            default: ;
          endcase
        end
      end
      S_MX: begin
        cmd_o.mul_x = 1'b1;
        state_d = S_MY;
      end
      S_MY: begin
        cmd_o.mul_y = 1'b1;
        state_d = S_MAP;
      end
      S_MAP: begin
        cmd_o.fin_map = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) state_d = S_DRN1;
      end
      S_DRN1: begin
        cmd_o.scan_cmp = 1'b1;
        state_d = S_DRN2;
      end
      S_DRN2: begin
        cmd_o.scan_cmp = 1'b1;
        state_d = S_CA;
      end
      S_CA: begin
        cmd_o.cost_a = 1'b1;
        state_d = S_CB;
      end
      S_CB: begin
        cmd_o.cost_b = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        cmd_o.out_load = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // Compare stage runs in the cycle after each read
    if (state_q == S_SCAN) cmd_o.scan_cmp = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/law_dp.sv
// Datapath: transform, landmark table, nearest search and cost.
`timescale 1ns / 1ps
module law_dp #(
  parameter int MAX_LANDMARKS = 64,
  parameter int COORD_BITS    = 24,
  parameter int IDX_BITS      = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  law_pkg::law_cmd_t            cmd_i,
  output law_pkg::law_sts_t            sts_o,
  input  logic [6:0]                   landmark_count,
  input  logic [15:0]                  x_error_scale,
  input  logic [15:0]                  y_error_scale,
  input  logic [5:0]                   landmark_slot,
  input  logic signed [COORD_BITS-1:0] landmark_x,
  input  logic signed [COORD_BITS-1:0] landmark_y,
  input  logic signed [COORD_BITS-1:0] pose_x,
  input  logic signed [COORD_BITS-1:0] pose_y,
  input  logic [15:0]                  heading,
  input  logic signed [COORD_BITS-1:0] obs_x,
  input  logic signed [COORD_BITS-1:0] obs_y,
  input  logic                         final_obs,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [5:0]                   match_index,
  output logic signed [COORD_BITS-1:0] map_x,
  output logic signed [COORD_BITS-1:0] map_y,
  output logic [31:0]                  term_cost,
  output logic [31:0]                  total_cost,
  output logic                         particle_done
);

  localparam int CB  = COORD_BITS;
  localparam int PB  = CB + 16;       // product width
  localparam int DB  = CB + 2;        // difference width
  localparam int SB  = 2 * (DB - 1);  // square magnitude width
  localparam int CNTB = IDX_BITS + 1;
  localparam logic [CNTB-1:0] MAXN = CNTB'(MAX_LANDMARKS);

  // Landmark tables
  logic signed [CB-1:0] lx_mem [MAX_LANDMARKS];
  logic signed [CB-1:0] ly_mem [MAX_LANDMARKS];
  logic signed [CB-1:0] rdx_q, rdy_q;

  // Pose and observation
  logic signed [CB-1:0] px_q, py_q, ox_q, oy_q;
  logic [15:0]          hd_q;
  logic                 fin_q;
  logic signed [15:0]   s_w, c_w;
  logic [6:0]           step_w;
  logic signed [PB-1:0] p1_q, p2_q, accx_q;
  logic signed [CB-1:0] mx_q, my_q;

  // Search
  logic [CNTB-1:0]      n_w, rd_q;
  logic [IDX_BITS-1:0]  cidx_q, bidx_q;
  logic                 cvld_q, first_q;
  logic [SB:0]          bd_q, cd_w;
  logic signed [CB-1:0] bx_q, by_q;
  logic [SB-1:0]        cdx_w, cdy_w, sqx_q, sqy_q;
  logic [SB+16:0]       tx_q, ty_q;
  logic [SB+17:0]       sum_w;
  logic [31:0]          term_w;
  logic [31:0]          cost_sum_q;
  logic [32:0]          tot_w;

  function automatic logic [SB-1:0] sqmag(input logic signed [CB-1:0] a,
                                          input logic signed [CB-1:0] b);
    logic signed [DB-1:0] d;
    logic [DB-2:0]        m;
    d = DB'(a) - DB'(b);
    m = d[DB-1] ? (DB-1)'(-d) : d[DB-2:0];
    return m * m;
  endfunction

  function automatic logic signed [CB-1:0] sat_c(input logic signed [PB-1:0] v);
    logic signed [PB-1:0] hi, lo;
    hi = PB'({1'b0, {(CB-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[CB-1:0];
    if (v < lo) return lo[CB-1:0];
    return v[CB-1:0];
  endfunction

  // Trig from the latched heading
  assign step_w = hd_q[15:9];
  assign s_w = law_pkg::sine_q14(step_w);
  assign c_w = law_pkg::sine_q14(step_w + 7'd32);

  // Effective count, clamped to 1..MAX
  always_comb begin
    n_w = (landmark_count == 7'd0) ? CNTB'(1) : CNTB'(landmark_count);
    if (CNTB'(landmark_count) > MAXN || (CNTB < 7 && landmark_count > 7'(MAX_LANDMARKS)))
      n_w = MAXN;
  end
  assign sts_o.scan_last = (rd_q + 1'b1 >= n_w);

  // Table write and read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_lm && 32'(landmark_slot) < 32'(MAX_LANDMARKS)) begin
      lx_mem[IDX_BITS'(landmark_slot)] <= landmark_x;
      ly_mem[IDX_BITS'(landmark_slot)] <= landmark_y;
    end
    rdx_q <= lx_mem[rd_q[IDX_BITS-1:0]];
    rdy_q <= ly_mem[rd_q[IDX_BITS-1:0]];
  end

  // Distance of the entry returned by the table
  assign cdx_w = sqmag(mx_q, rdx_q);
  assign cdy_w = sqmag(my_q, rdy_q);
  assign cd_w  = {1'b0, cdx_w} + {1'b0, cdy_w};

  assign sum_w = {1'b0, tx_q} + {1'b0, ty_q} + (SB+18)'(32768);
  assign tot_w = {1'b0, cost_sum_q} + {1'b0, term_w};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; hd_q <= '0;
      cost_sum_q <= '0;
      rd_q <= '0; cvld_q <= 1'b0; first_q <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_i.set_pose) begin
        px_q <= pose_x; py_q <= pose_y; hd_q <= heading;
        cost_sum_q <= '0;
      end
      if (cmd_i.start_obs) begin
        rd_q <= '0; first_q <= 1'b1;
      end
      // Read pipeline: address, data, compare
      cvld_q <= cmd_i.scan_rd;
      cidx_q <= rd_q[IDX_BITS-1:0];
      if (cmd_i.scan_rd) rd_q <= rd_q + 1'b1;
      if (cmd_i.scan_cmp && cvld_q) begin
        if (first_q || cd_w < bd_q) begin
          bd_q <= cd_w; bidx_q <= cidx_q; bx_q <= rdx_q; by_q <= rdy_q;
        end
        first_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        cost_sum_q <= tot_w[32] ? 32'hFFFF_FFFF : tot_w[31:0];
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_obs) begin
      ox_q <= obs_x; oy_q <= obs_y; fin_q <= final_obs;
    end
    if (cmd_i.mul_x) begin
      p1_q <= PB'(c_w * ox_q);
      p2_q <= PB'(s_w * oy_q);
    end
    if (cmd_i.mul_y) begin
      accx_q <= p1_q - p2_q + PB'(8192);
      p1_q <= PB'(s_w * ox_q);
      p2_q <= PB'(c_w * oy_q);
    end
    if (cmd_i.fin_map) begin
      mx_q <= sat_c(PB'(px_q) + (accx_q >>> 14));
      my_q <= sat_c(PB'(py_q) + ((p1_q + p2_q + PB'(8192)) >>> 14));
    end
    if (cmd_i.cost_a) begin
      sqx_q <= sqmag(mx_q, bx_q);
      sqy_q <= sqmag(my_q, by_q);
    end
    if (cmd_i.cost_b) begin
      tx_q <= sqx_q * x_error_scale;
      ty_q <= sqy_q * y_error_scale;
    end
    if (cmd_i.out_load) begin
      match_index <= 6'(bidx_q);
      map_x <= mx_q;
      map_y <= my_q;
      term_cost <= term_w;
      total_cost <= tot_w[32] ? 32'hFFFF_FFFF : tot_w[31:0];
      particle_done <= fin_q;
    end
  end

  // Rounded cost, saturated to 32 bits
  always_comb begin
    if (|sum_w[SB+17:48]) term_w = 32'hFFFF_FFFF;
    else term_w = sum_w[47:16];
  end

endmodule
